// ===== src/slbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Subresource layout barrier tracker package
// Shared types, field widths, layout codes, access bits and mask functions.
// ----------------------------------------------------------------------------
package slbt_pkg;

    localparam int LAYOUT_W = 4;
    localparam int FAMILY_W = 4;
    localparam int OWNER_W  = 5;
    localparam int COORD_W  = 3;
    localparam int SPAN_W   = 8;
    localparam int ASPECT_W = 4;
    localparam int COUNT_W  = 4;
    localparam int ACCESS_W = 32;
    localparam int ENTRY_W  = OWNER_W + LAYOUT_W;
    localparam int RECCNT_W = 7;

    localparam logic [RECCNT_W-1:0] RESULT_LIMIT  = 7'd64;
    localparam logic [OWNER_W-1:0]  OWNER_IGNORED = 5'd16;

    // Configuration register indexes.
    localparam logic CFG_LAYER_COUNT = 1'b0;
    localparam logic CFG_MIP_COUNT   = 1'b1;

    // Layout codes.
    localparam logic [LAYOUT_W-1:0] LAYOUT_UNDEFINED     = 4'd0;
    localparam logic [LAYOUT_W-1:0] LAYOUT_PREINIT       = 4'd1;
    localparam logic [LAYOUT_W-1:0] LAYOUT_COLOR_ATT     = 4'd2;
    localparam logic [LAYOUT_W-1:0] LAYOUT_DEPTH_ATT     = 4'd3;
    localparam logic [LAYOUT_W-1:0] LAYOUT_XFER_SRC      = 4'd4;
    localparam logic [LAYOUT_W-1:0] LAYOUT_XFER_DST      = 4'd5;
    localparam logic [LAYOUT_W-1:0] LAYOUT_SHADER_RO     = 4'd6;
    localparam logic [LAYOUT_W-1:0] LAYOUT_GENERAL       = 4'd7;

    // Access mask bits.
    localparam logic [ACCESS_W-1:0] ACC_NONE     = 32'h0000_0000;
    localparam logic [ACCESS_W-1:0] ACC_HOST_W   = 32'h0000_4000;
    localparam logic [ACCESS_W-1:0] ACC_COLOR_W  = 32'h0000_0100;
    localparam logic [ACCESS_W-1:0] ACC_DEPTH_W  = 32'h0000_0400;
    localparam logic [ACCESS_W-1:0] ACC_XFER_R   = 32'h0000_0800;
    localparam logic [ACCESS_W-1:0] ACC_XFER_W   = 32'h0000_1000;
    localparam logic [ACCESS_W-1:0] ACC_SHADER_R = 32'h0000_0020;
    localparam logic [ACCESS_W-1:0] ACC_SHADER_W = 32'h0000_0040;
    localparam logic [ACCESS_W-1:0] ACC_ALL      = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic setup;
        logic issue;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic empty;
        logic issue_last;
    } t_stat;

    function automatic logic [ACCESS_W-1:0] src_mask(input logic [LAYOUT_W-1:0] code);
        logic [ACCESS_W-1:0] m;
        unique case (code)
            LAYOUT_UNDEFINED: m = ACC_NONE;
            LAYOUT_PREINIT:   m = ACC_HOST_W;
            LAYOUT_COLOR_ATT: m = ACC_COLOR_W;
            LAYOUT_DEPTH_ATT: m = ACC_DEPTH_W;
            LAYOUT_XFER_SRC:  m = ACC_XFER_R;
            LAYOUT_XFER_DST:  m = ACC_XFER_W;
            LAYOUT_SHADER_RO: m = ACC_SHADER_R;
            LAYOUT_GENERAL:   m = ACC_SHADER_R | ACC_SHADER_W;
            default:          m = ACC_ALL;
        endcase
        return m;
    endfunction

    function automatic logic [ACCESS_W-1:0] dst_mask(input logic [LAYOUT_W-1:0] code);
        logic [ACCESS_W-1:0] m;
        unique case (code)
            LAYOUT_COLOR_ATT: m = ACC_COLOR_W;
            LAYOUT_DEPTH_ATT: m = ACC_DEPTH_W;
            LAYOUT_XFER_SRC:  m = ACC_XFER_R;
            LAYOUT_XFER_DST:  m = ACC_XFER_W;
            LAYOUT_SHADER_RO: m = ACC_SHADER_R;
            LAYOUT_GENERAL:   m = ACC_SHADER_R | ACC_SHADER_W;
            default:          m = ACC_ALL;
        endcase
        return m;
    endfunction

endpackage

// ===== src/slbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Barrier tracker controller
// Sequences the table clearing pass, request setup, the entry walk and the
// final record flush.
// ----------------------------------------------------------------------------
module slbt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  slbt_pkg::t_stat  i_stat,
    output slbt_pkg::t_cmd   o_cmd
);

    slbt_pkg::t_state r_state;
    slbt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slbt_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            slbt_pkg::ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = slbt_pkg::ST_IDLE;
                end
            end
            slbt_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = slbt_pkg::ST_SETUP;
                end
            end
            slbt_pkg::ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = i_stat.empty ? slbt_pkg::ST_FINAL : slbt_pkg::ST_WALK;
            end
            slbt_pkg::ST_WALK: begin
                o_cmd.issue = 1'b1;
                if (i_stat.issue_last) begin
                    n_state = slbt_pkg::ST_DRAIN;
                end
            end
            // The last entry read is compared and written back here.
            slbt_pkg::ST_DRAIN: begin
                n_state = slbt_pkg::ST_FINAL;
            end
            slbt_pkg::ST_FINAL: begin
                o_cmd.finish = 1'b1;
                n_state      = slbt_pkg::ST_IDLE;
            end
            default: begin
                n_state = slbt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/slbt_datapath.sv =====
// ----------------------------------------------------------------------------
// Barrier tracker datapath
// Holds the configuration, the request, the walk counters, the subresource
// state memory and the one-deep record holding stage in front of the outputs.
// ----------------------------------------------------------------------------
module slbt_datapath #(
    parameter int MAX_LAYERS = 8,
    parameter int MAX_MIPS   = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  slbt_pkg::t_cmd                    i_cmd,
    output slbt_pkg::t_stat                   o_stat,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [slbt_pkg::COUNT_W-1:0]      i_cfg_data,
    input  logic [slbt_pkg::LAYOUT_W-1:0]     i_target_layout,
    input  logic [slbt_pkg::FAMILY_W-1:0]     i_target_family,
    input  logic [slbt_pkg::COORD_W-1:0]      i_first_layer,
    input  logic [slbt_pkg::SPAN_W-1:0]       i_layer_span,
    input  logic [slbt_pkg::COORD_W-1:0]      i_first_mip,
    input  logic [slbt_pkg::SPAN_W-1:0]       i_mip_span,
    input  logic [slbt_pkg::ASPECT_W-1:0]     i_aspect_bits,
    output logic                              o_valid,
    output logic [slbt_pkg::COORD_W-1:0]      o_layer_at,
    output logic [slbt_pkg::COORD_W-1:0]      o_mip_at,
    output logic [slbt_pkg::ASPECT_W-1:0]     o_aspect_out,
    output logic [slbt_pkg::LAYOUT_W-1:0]     o_prior_layout,
    output logic [slbt_pkg::LAYOUT_W-1:0]     o_next_layout,
    output logic [slbt_pkg::FAMILY_W-1:0]     o_source_family,
    output logic [slbt_pkg::FAMILY_W-1:0]     o_dest_family,
    output logic [slbt_pkg::ACCESS_W-1:0]     o_source_access,
    output logic [slbt_pkg::ACCESS_W-1:0]     o_dest_access,
    output logic                              o_final_barrier
);

    localparam int DEPTH = MAX_LAYERS * MAX_MIPS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = slbt_pkg::COUNT_W;
    localparam int LW    = slbt_pkg::LAYOUT_W;
    localparam int FW    = slbt_pkg::FAMILY_W;
    localparam int AW    = slbt_pkg::ACCESS_W;
    localparam int XW    = slbt_pkg::COORD_W;
    localparam int PROD_W = slbt_pkg::COORD_W + slbt_pkg::COUNT_W;

    // Configuration registers.
    logic [CW-1:0] r_layer_cnt;
    logic [CW-1:0] r_mip_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_cnt <= 4'd1;
            r_mip_cnt   <= 4'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == slbt_pkg::CFG_LAYER_COUNT) begin
                r_layer_cnt <= i_cfg_data;
            end else begin
                r_mip_cnt <= i_cfg_data;
            end
        end
    end

    // Effective image size and clamped range ends.
    localparam int SPAN_SUM_W = slbt_pkg::SPAN_W + 1;
    logic [CW-1:0]         layers_eff;
    logic [CW-1:0]         mips_eff;
    logic [SPAN_SUM_W-1:0] lsum;
    logic [SPAN_SUM_W-1:0] msum;
    logic [CW-1:0]         lend_c;
    logic [CW-1:0]         mend_c;

    always_comb begin
        layers_eff = (int'(r_layer_cnt) > MAX_LAYERS) ? CW'(MAX_LAYERS) : r_layer_cnt;
        mips_eff   = (int'(r_mip_cnt) > MAX_MIPS) ? CW'(MAX_MIPS) : r_mip_cnt;
        lsum = SPAN_SUM_W'(i_first_layer) + SPAN_SUM_W'(i_layer_span);
        msum = SPAN_SUM_W'(i_first_mip) + SPAN_SUM_W'(i_mip_span);
        lend_c = (lsum > SPAN_SUM_W'(layers_eff)) ? layers_eff : lsum[CW-1:0];
        mend_c = (msum > SPAN_SUM_W'(mips_eff)) ? mips_eff : msum[CW-1:0];
    end

    // Request registers.
    logic [LW-1:0]                    r_layout;
    logic [FW-1:0]                    r_family;
    logic [slbt_pkg::ASPECT_W-1:0]    r_aspect;
    logic [XW-1:0]                    r_l0;
    logic [XW-1:0]                    r_m0;
    logic [CW-1:0]                    r_lend;
    logic [CW-1:0]                    r_mend;
    logic [CW-1:0]                    r_mips;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_layout <= i_target_layout;
            r_family <= i_target_family;
            r_aspect <= i_aspect_bits;
            r_l0     <= i_first_layer;
            r_m0     <= i_first_mip;
            r_lend   <= lend_c;
            r_mend   <= mend_c;
            r_mips   <= mips_eff;
        end
    end

    // Walk counters: layer-major, mips inner, row base kept incrementally.
    logic [CW-1:0]     r_l;
    logic [CW-1:0]     r_m;
    logic [IDX_W-1:0]  r_base;
    logic [PROD_W-1:0] base0;
    logic              row_last;
    logic [IDX_W-1:0]  rd_addr;

    assign base0    = PROD_W'(r_l0) * PROD_W'(r_mips);
    assign row_last = ({1'b0, r_m} + 5'd1) == {1'b0, r_mend};
    assign rd_addr  = r_base + IDX_W'(r_m);

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_l    <= CW'(r_l0);
            r_m    <= CW'(r_m0);
            r_base <= IDX_W'(base0);
        end else if (i_cmd.issue) begin
            if (row_last) begin
                r_m    <= CW'(r_m0);
                r_l    <= r_l + 4'd1;
                r_base <= r_base + IDX_W'(r_mips);
            end else begin
                r_m <= r_m + 4'd1;
            end
        end
    end

    // Clearing pass address.
    logic [IDX_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
        end
    end

    assign o_stat.clear_last = (r_clr_addr == IDX_W'(DEPTH - 1));
    assign o_stat.empty      = ({1'b0, r_l0} >= r_lend) || ({1'b0, r_m0} >= r_mend);
    assign o_stat.issue_last = row_last && (({1'b0, r_l} + 5'd1) == {1'b0, r_lend});

    // Subresource state memory: {owner, layout} per entry.
    logic [slbt_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [slbt_pkg::ENTRY_W-1:0] r_rd_data;
    logic                         r_s1_valid;
    logic [IDX_W-1:0]             r_s1_addr;
    logic [XW-1:0]                r_s1_l;
    logic [XW-1:0]                r_s1_m;

    logic [LW-1:0]                old_layout;
    logic [slbt_pkg::OWNER_W-1:0] old_owner;
    logic                         changed;
    logic                         take_rec;
    logic [AW-1:0]                src_acc;
    logic [FW-1:0]                src_fam;

    assign old_layout = r_rd_data[LW-1:0];
    assign old_owner  = r_rd_data[slbt_pkg::ENTRY_W-1:LW];
    assign changed    = r_s1_valid &&
                        ((old_layout != r_layout) || (old_owner != {1'b0, r_family}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            mem[r_clr_addr] <= {slbt_pkg::OWNER_IGNORED, slbt_pkg::LAYOUT_UNDEFINED};
        end else if (changed) begin
            mem[r_s1_addr] <= {1'b0, r_family, r_layout};
        end
        if (i_cmd.issue) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_s1_addr <= rd_addr;
            r_s1_l    <= r_l[XW-1:0];
            r_s1_m    <= r_m[XW-1:0];
        end
    end

    always_comb begin
        src_acc = slbt_pkg::src_mask(old_layout);
        if ((r_layout == slbt_pkg::LAYOUT_SHADER_RO) && (src_acc == slbt_pkg::ACC_NONE)) begin
            src_acc = slbt_pkg::ACC_HOST_W | slbt_pkg::ACC_XFER_W;
        end
        src_fam = (old_owner == slbt_pkg::OWNER_IGNORED) ? r_family : old_owner[FW-1:0];
    end

    // One record is held back until it is known whether it is the last one.
    logic [slbt_pkg::RECCNT_W-1:0] r_rec_cnt;
    logic                          r_pend_valid;
    logic [XW-1:0]                 r_p_l;
    logic [XW-1:0]                 r_p_m;
    logic [LW-1:0]                 r_p_prior;
    logic [FW-1:0]                 r_p_src_fam;
    logic [AW-1:0]                 r_p_src_acc;

    assign take_rec = changed && (r_rec_cnt < slbt_pkg::RESULT_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_cnt    <= '0;
            r_pend_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_rec_cnt    <= '0;
            r_pend_valid <= 1'b0;
        end else if (take_rec) begin
            r_rec_cnt    <= r_rec_cnt + 7'd1;
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_rec) begin
            r_p_l       <= r_s1_l;
            r_p_m       <= r_s1_m;
            r_p_prior   <= old_layout;
            r_p_src_fam <= src_fam;
            r_p_src_acc <= src_acc;
        end
    end

    // Output register: a held record leaves when a newer one replaces it or
    // when the request ends.
    logic r_out_valid;
    logic emit;

    assign emit = r_pend_valid && (take_rec || i_cmd.finish);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_layer_at      <= r_p_l;
            o_mip_at        <= r_p_m;
            o_aspect_out    <= r_aspect;
            o_prior_layout  <= r_p_prior;
            o_next_layout   <= r_layout;
            o_source_family <= r_p_src_fam;
            o_dest_family   <= r_family;
            o_source_access <= r_p_src_acc;
            o_dest_access   <= slbt_pkg::dst_mask(r_layout);
            o_final_barrier <= i_cmd.finish;
        end
    end

    assign o_valid = r_out_valid;

    a_rec_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rec_cnt <= slbt_pkg::RESULT_LIMIT)
        else $error("record count passed the limit");

    a_pend_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_rec_cnt != '0))
        else $error("held record without a counted record");

    a_finish_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (!r_pend_valid && (r_rec_cnt == '0)))
        else $error("held record survived the end of a request");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !i_cmd.clear_step)
        else $error("entry update during the clearing pass");

endmodule

// ===== src/subresource_layout_barrier_tracker.sv =====
// ----------------------------------------------------------------------------
// Subresource layout barrier tracker
// Tracks layout and owning queue family per subresource and emits one barrier
// record for each entry that a transition request changes, up to 64 per request.
// ----------------------------------------------------------------------------
// Busy stays high from an accepted request through the setup, walk, drain and
// final states; the walk covers the clamped range (at most 64 entries by default),
// one entry per cycle, and is skipped if the range is empty. One request runs at a
// time. A record passes the read, holding and output registers after its entry is
// read, the last in the first cycle with busy low; results cannot be stalled.
// Reset: a clearing pass over MAX_LAYERS*MAX_MIPS entries runs with busy high.
module subresource_layout_barrier_tracker #(
    parameter int MAX_LAYERS = 8,
    parameter int MAX_MIPS   = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [slbt_pkg::COUNT_W-1:0]      i_cfg_data,
    input  logic [slbt_pkg::LAYOUT_W-1:0]     i_target_layout,
    input  logic [slbt_pkg::FAMILY_W-1:0]     i_target_family,
    input  logic [slbt_pkg::COORD_W-1:0]      i_first_layer,
    input  logic [slbt_pkg::SPAN_W-1:0]       i_layer_span,
    input  logic [slbt_pkg::COORD_W-1:0]      i_first_mip,
    input  logic [slbt_pkg::SPAN_W-1:0]       i_mip_span,
    input  logic [slbt_pkg::ASPECT_W-1:0]     i_aspect_bits,
    output logic                              o_valid,
    output logic [slbt_pkg::COORD_W-1:0]      o_layer_at,
    output logic [slbt_pkg::COORD_W-1:0]      o_mip_at,
    output logic [slbt_pkg::ASPECT_W-1:0]     o_aspect_out,
    output logic [slbt_pkg::LAYOUT_W-1:0]     o_prior_layout,
    output logic [slbt_pkg::LAYOUT_W-1:0]     o_next_layout,
    output logic [slbt_pkg::FAMILY_W-1:0]     o_source_family,
    output logic [slbt_pkg::FAMILY_W-1:0]     o_dest_family,
    output logic [slbt_pkg::ACCESS_W-1:0]     o_source_access,
    output logic [slbt_pkg::ACCESS_W-1:0]     o_dest_access,
    output logic                              o_final_barrier
);

    slbt_pkg::t_cmd  cmd;
    slbt_pkg::t_stat stat;

    slbt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    slbt_datapath #(
        .MAX_LAYERS (MAX_LAYERS),
        .MAX_MIPS   (MAX_MIPS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_target_layout (i_target_layout),
        .i_target_family (i_target_family),
        .i_first_layer   (i_first_layer),
        .i_layer_span    (i_layer_span),
        .i_first_mip     (i_first_mip),
        .i_mip_span      (i_mip_span),
        .i_aspect_bits   (i_aspect_bits),
        .o_valid         (o_valid),
        .o_layer_at      (o_layer_at),
        .o_mip_at        (o_mip_at),
        .o_aspect_out    (o_aspect_out),
        .o_prior_layout  (o_prior_layout),
        .o_next_layout   (o_next_layout),
        .o_source_family (o_source_family),
        .o_dest_family   (o_dest_family),
        .o_source_access (o_source_access),
        .o_dest_access   (o_dest_access),
        .o_final_barrier (o_final_barrier)
    );

endmodule

// ===== tb/tb_subresource_layout_barrier_tracker.sv =====
// ----------------------------------------------------------------------------
// Subresource layout barrier tracker testbench
// Drives transition requests and count register writes into the tracker,
// mirrors its layout and owner tables, and checks every barrier record
// against the predicted stream, field by field, in order.
// ----------------------------------------------------------------------------
module tb_subresource_layout_barrier_tracker;

    localparam int MAX_L  = 8;
    localparam int MAX_M  = 8;
    localparam int DEPTH  = MAX_L * MAX_M;
    localparam int SETTLE = 8;
    localparam int DRAIN  = 80;

    localparam int LW = slbt_pkg::LAYOUT_W;
    localparam int FW = slbt_pkg::FAMILY_W;
    localparam int XW = slbt_pkg::COORD_W;
    localparam int SW = slbt_pkg::SPAN_W;
    localparam int PW = slbt_pkg::ASPECT_W;
    localparam int AW = slbt_pkg::ACCESS_W;
    localparam int CW = slbt_pkg::COUNT_W;
    localparam int OW = slbt_pkg::OWNER_W;

    localparam logic [LW-1:0] LAYOUT_OTHER = 4'd8;
    localparam logic [LW-1:0] LAYOUT_BAD   = 4'd15;

    typedef struct {
        logic [XW-1:0] layer_at;
        logic [XW-1:0] mip_at;
        logic [PW-1:0] aspect;
        logic [LW-1:0] prior_layout;
        logic [LW-1:0] next_layout;
        logic [FW-1:0] src_family;
        logic [FW-1:0] dst_family;
        logic [AW-1:0] src_access;
        logic [AW-1:0] dst_access;
        logic          last_of_req;
    } t_barrier;

    typedef struct {
        logic          is_cfg;
        logic          cfg_idx;
        logic [CW-1:0] cfg_val;
        logic [LW-1:0] layout;
        logic [FW-1:0] family;
        logic [XW-1:0] first_layer;
        logic [SW-1:0] layer_span;
        logic [XW-1:0] first_mip;
        logic [SW-1:0] mip_span;
        logic [PW-1:0] aspect;
        int            gap;
    } t_work;

    logic          i_clk           = 1'b0;
    logic          i_rst_n         = 1'b0;
    logic          start           = 1'b0;
    logic          busy;
    logic          i_cfg_we        = 1'b0;
    logic          i_cfg_idx       = 1'b0;
    logic [CW-1:0] i_cfg_data      = '0;
    logic [LW-1:0] i_target_layout = '0;
    logic [FW-1:0] i_target_family = '0;
    logic [XW-1:0] i_first_layer   = '0;
    logic [SW-1:0] i_layer_span    = '0;
    logic [XW-1:0] i_first_mip     = '0;
    logic [SW-1:0] i_mip_span      = '0;
    logic [PW-1:0] i_aspect_bits   = '0;
    logic          o_valid;
    logic [XW-1:0] o_layer_at;
    logic [XW-1:0] o_mip_at;
    logic [PW-1:0] o_aspect_out;
    logic [LW-1:0] o_prior_layout;
    logic [LW-1:0] o_next_layout;
    logic [FW-1:0] o_source_family;
    logic [FW-1:0] o_dest_family;
    logic [AW-1:0] o_source_access;
    logic [AW-1:0] o_dest_access;
    logic          o_final_barrier;

    subresource_layout_barrier_tracker #(
        .MAX_LAYERS (MAX_L),
        .MAX_MIPS   (MAX_M)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_target_layout (i_target_layout),
        .i_target_family (i_target_family),
        .i_first_layer   (i_first_layer),
        .i_layer_span    (i_layer_span),
        .i_first_mip     (i_first_mip),
        .i_mip_span      (i_mip_span),
        .i_aspect_bits   (i_aspect_bits),
        .o_valid         (o_valid),
        .o_layer_at      (o_layer_at),
        .o_mip_at        (o_mip_at),
        .o_aspect_out    (o_aspect_out),
        .o_prior_layout  (o_prior_layout),
        .o_next_layout   (o_next_layout),
        .o_source_family (o_source_family),
        .o_dest_family   (o_dest_family),
        .o_source_access (o_source_access),
        .o_dest_access   (o_dest_access),
        .o_final_barrier (o_final_barrier)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mirror of the tracker state.
    logic [LW-1:0] layout_mirror [DEPTH];
    logic [OW-1:0] owner_mirror  [DEPTH];
    logic [CW-1:0] mirror_layers;
    logic [CW-1:0] mirror_mips;

    t_barrier barrier_q [$];
    t_work    work_q [$];
    int       mismatches = 0;
    logic     req_taken  = 1'b0;

    function automatic logic [AW-1:0] release_access(input logic [LW-1:0] code);
        unique case (code)
            slbt_pkg::LAYOUT_UNDEFINED: return slbt_pkg::ACC_NONE;
            slbt_pkg::LAYOUT_PREINIT:   return slbt_pkg::ACC_HOST_W;
            slbt_pkg::LAYOUT_COLOR_ATT: return slbt_pkg::ACC_COLOR_W;
            slbt_pkg::LAYOUT_DEPTH_ATT: return slbt_pkg::ACC_DEPTH_W;
            slbt_pkg::LAYOUT_XFER_SRC:  return slbt_pkg::ACC_XFER_R;
            slbt_pkg::LAYOUT_XFER_DST:  return slbt_pkg::ACC_XFER_W;
            slbt_pkg::LAYOUT_SHADER_RO: return slbt_pkg::ACC_SHADER_R;
            slbt_pkg::LAYOUT_GENERAL:   return slbt_pkg::ACC_SHADER_R | slbt_pkg::ACC_SHADER_W;
            default:                    return slbt_pkg::ACC_ALL;
        endcase
    endfunction

    function automatic logic [AW-1:0] acquire_access(input logic [LW-1:0] code);
        unique case (code)
            slbt_pkg::LAYOUT_COLOR_ATT: return slbt_pkg::ACC_COLOR_W;
            slbt_pkg::LAYOUT_DEPTH_ATT: return slbt_pkg::ACC_DEPTH_W;
            slbt_pkg::LAYOUT_XFER_SRC:  return slbt_pkg::ACC_XFER_R;
            slbt_pkg::LAYOUT_XFER_DST:  return slbt_pkg::ACC_XFER_W;
            slbt_pkg::LAYOUT_SHADER_RO: return slbt_pkg::ACC_SHADER_R;
            slbt_pkg::LAYOUT_GENERAL:   return slbt_pkg::ACC_SHADER_R | slbt_pkg::ACC_SHADER_W;
            default:                    return slbt_pkg::ACC_ALL;
        endcase
    endfunction

    // Walks the clamped range layer-major; queues records for up to 64 changed entries.
    task automatic predict_barriers(
        input logic [LW-1:0] lay,
        input logic [FW-1:0] fam,
        input logic [XW-1:0] l0,
        input logic [SW-1:0] lspan,
        input logic [XW-1:0] m0,
        input logic [SW-1:0] mspan,
        input logic [PW-1:0] asp
    );
        int            layers;
        int            mips;
        int            lend;
        int            mend;
        int            idx;
        int            n;
        logic          held;
        t_barrier      rec;
        t_barrier      prev;
        logic [LW-1:0] old_lay;
        logic [OW-1:0] old_own;
        layers = (int'(mirror_layers) > MAX_L) ? MAX_L : int'(mirror_layers);
        mips   = (int'(mirror_mips) > MAX_M) ? MAX_M : int'(mirror_mips);
        lend   = int'(l0) + int'(lspan);
        mend   = int'(m0) + int'(mspan);
        if (lend > layers) lend = layers;
        if (mend > mips) mend = mips;
        n    = 0;
        held = 1'b0;
        for (int l = int'(l0); l < lend; l++) begin
            for (int m = int'(m0); m < mend; m++) begin
                idx = l * mips + m;
                if (idx < DEPTH) begin
                    old_lay = layout_mirror[idx];
                    old_own = owner_mirror[idx];
                    if (old_lay != lay || old_own != {1'b0, fam}) begin
                        layout_mirror[idx] = lay;
                        owner_mirror[idx]  = {1'b0, fam};
                        if (n < int'(slbt_pkg::RESULT_LIMIT)) begin
                            rec.layer_at     = XW'(l);
                            rec.mip_at       = XW'(m);
                            rec.aspect       = asp;
                            rec.prior_layout = old_lay;
                            rec.next_layout  = lay;
                            rec.src_family   = (old_own == slbt_pkg::OWNER_IGNORED)
                                               ? fam : old_own[FW-1:0];
                            rec.dst_family   = fam;
                            rec.src_access   = release_access(old_lay);
                            rec.dst_access   = acquire_access(lay);
                            // Leaving an undefined-like state into shader read needs host
                            // and transfer writes made visible.
                            if (lay == slbt_pkg::LAYOUT_SHADER_RO &&
                                rec.src_access == slbt_pkg::ACC_NONE)
                                rec.src_access = slbt_pkg::ACC_HOST_W | slbt_pkg::ACC_XFER_W;
                            rec.last_of_req  = 1'b0;
                            if (held) barrier_q = {barrier_q, prev};
                            prev = rec;
                            held = 1'b1;
                            n++;
                        end
                    end
                end
            end
        end
        if (held) begin
            prev.last_of_req = 1'b1;
            barrier_q = {barrier_q, prev};
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor and predictor: outputs and inputs are sampled at the rising edge.
    always @(posedge i_clk) begin
        t_barrier want;
        req_taken <= i_rst_n && start && !busy;
        if (!i_rst_n) begin
            mirror_layers = 4'd1;
            mirror_mips   = 4'd1;
            for (int k = 0; k < DEPTH; k++) begin
                layout_mirror[k] = slbt_pkg::LAYOUT_UNDEFINED;
                owner_mirror[k]  = slbt_pkg::OWNER_IGNORED;
            end
        end else begin
            if (o_valid) begin
                if (barrier_q.size() == 0) begin
                    $error("unexpected barrier record at layer %0d mip %0d",
                           o_layer_at, o_mip_at);
                    mismatches++;
                end else begin
                    want = barrier_q.pop_front();
                    check_field("layer_at", 32'(want.layer_at), 32'(o_layer_at));
                    check_field("mip_at", 32'(want.mip_at), 32'(o_mip_at));
                    check_field("aspect_out", 32'(want.aspect), 32'(o_aspect_out));
                    check_field("prior_layout", 32'(want.prior_layout), 32'(o_prior_layout));
                    check_field("next_layout", 32'(want.next_layout), 32'(o_next_layout));
                    check_field("source_family", 32'(want.src_family), 32'(o_source_family));
                    check_field("dest_family", 32'(want.dst_family), 32'(o_dest_family));
                    check_field("source_access", want.src_access, o_source_access);
                    check_field("dest_access", want.dst_access, o_dest_access);
                    check_field("final_barrier", 32'(want.last_of_req), 32'(o_final_barrier));
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    slbt_pkg::CFG_LAYER_COUNT: mirror_layers = i_cfg_data;
                    slbt_pkg::CFG_MIP_COUNT:   mirror_mips   = i_cfg_data;
                endcase
            end
            if (start && !busy)
                predict_barriers(i_target_layout, i_target_family, i_first_layer,
                                 i_layer_span, i_first_mip, i_mip_span, i_aspect_bits);
        end
    end

    // Driver: inputs change at the falling edge.
    t_work cur;
    logic  have_op    = 1'b0;
    int    gap_cnt    = 0;
    int    settle_cnt = 0;

    always @(negedge i_clk) begin
        logic start_n;
        logic we_n;
        start_n = start;
        we_n    = 1'b0;
        if (i_rst_n) begin
            if (req_taken) begin
                start_n = 1'b0;
                have_op = 1'b0;
            end
            if (!start_n && !have_op && work_q.size() != 0) begin
                cur        = work_q.pop_front();
                have_op    = 1'b1;
                gap_cnt    = cur.gap;
                settle_cnt = 0;
            end
            if (!start_n && have_op) begin
                if (cur.is_cfg) begin
                    // A request can run with no records, so wait for a quiet stretch.
                    if (!busy && barrier_q.size() == 0) settle_cnt++;
                    else settle_cnt = 0;
                    if (settle_cnt >= SETTLE) begin
                        i_cfg_idx  <= cur.cfg_idx;
                        i_cfg_data <= cur.cfg_val;
                        we_n       = 1'b1;
                        have_op    = 1'b0;
                    end
                end else if (gap_cnt > 0) begin
                    gap_cnt--;
                end else begin
                    i_target_layout <= cur.layout;
                    i_target_family <= cur.family;
                    i_first_layer   <= cur.first_layer;
                    i_layer_span    <= cur.layer_span;
                    i_first_mip     <= cur.first_mip;
                    i_mip_span      <= cur.mip_span;
                    i_aspect_bits   <= cur.aspect;
                    start_n         = 1'b1;
                end
            end
        end
        start    <= start_n;
        i_cfg_we <= we_n;
    end

    task automatic add_config(input logic idx, input int val);
        t_work w;
        w         = '{default: '0};
        w.is_cfg  = 1'b1;
        w.cfg_idx = idx;
        w.cfg_val = CW'(val);
        work_q    = {work_q, w};
    endtask

    task automatic add_request(input int lay, input int fam, input int l0, input int lspan,
                               input int m0, input int mspan, input int asp, input int gap);
        t_work w;
        w             = '{default: '0};
        w.is_cfg      = 1'b0;
        w.layout      = LW'(lay);
        w.family      = FW'(fam);
        w.first_layer = XW'(l0);
        w.layer_span  = SW'(lspan);
        w.first_mip   = XW'(m0);
        w.mip_span    = SW'(mspan);
        w.aspect      = PW'(asp);
        w.gap         = gap;
        work_q        = {work_q, w};
    endtask

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 9);
        unique case (r)
            0:       return 0;
            1:       return 15;
            2, 3:    return MAX_L;
            4:       return 1;
            5:       return $urandom_range(0, 15);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int pick_span();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(0, 9);
        if (r < 9) return $urandom_range(0, 255);
        return 255;
    endfunction

    initial begin
        int lay;
        int fam;
        logic bursty;
        // Directed part.
        add_request(slbt_pkg::LAYOUT_PREINIT, 2, 0, 1, 0, 1, 3, 0);
        add_config(slbt_pkg::CFG_LAYER_COUNT, MAX_L);
        add_config(slbt_pkg::CFG_MIP_COUNT, MAX_M);
        // Undefined into shader read from an unowned entry, then an exact repeat.
        add_request(slbt_pkg::LAYOUT_SHADER_RO, 0, 0, 255, 0, 255, 15, 0);
        add_request(slbt_pkg::LAYOUT_SHADER_RO, 0, 0, 255, 0, 255, 15, 3);
        // Owner change only.
        add_request(slbt_pkg::LAYOUT_SHADER_RO, 3, 0, 8, 0, 8, 1, 0);
        for (int c = 0; c <= LAYOUT_OTHER; c++)
            add_request(c, c, 0, 255, 0, 255, c, c % 3);
        add_request(LAYOUT_BAD, 15, 0, 8, 0, 8, 0, 0);
        add_request(slbt_pkg::LAYOUT_SHADER_RO, 15, 0, 8, 0, 8, 0, 1);
        add_request(slbt_pkg::LAYOUT_COLOR_ATT, 5, 7, 255, 7, 255, 2, 0);
        add_request(slbt_pkg::LAYOUT_DEPTH_ATT, 5, 3, 0, 2, 4, 4, 0);
        add_request(slbt_pkg::LAYOUT_GENERAL, 9, 2, 3, 6, 200, 8, 2);
        add_config(slbt_pkg::CFG_LAYER_COUNT, 0);
        add_request(slbt_pkg::LAYOUT_XFER_DST, 1, 0, 255, 0, 255, 5, 0);
        add_config(slbt_pkg::CFG_LAYER_COUNT, 15);
        add_config(slbt_pkg::CFG_MIP_COUNT, 15);
        add_request(slbt_pkg::LAYOUT_XFER_DST, 1, 0, 255, 0, 255, 5, 0);
        // Table is not cleared: the same storage is reread under a new indexing.
        add_config(slbt_pkg::CFG_LAYER_COUNT, 3);
        add_config(slbt_pkg::CFG_MIP_COUNT, 5);
        add_request(slbt_pkg::LAYOUT_XFER_SRC, 1, 0, 255, 0, 255, 10, 0);

        // Random phases, each under a fresh geometry.
        for (int p = 0; p < 8; p++) begin
            add_config(slbt_pkg::CFG_LAYER_COUNT, pick_count());
            add_config(slbt_pkg::CFG_MIP_COUNT, pick_count());
            bursty = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 50; k++) begin
                lay = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(0, 15);
                fam = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
                add_request(lay, fam, $urandom_range(0, 7), pick_span(),
                            $urandom_range(0, 7), pick_span(), $urandom_range(0, 15),
                            bursty ? 0 : $urandom_range(0, 8));
            end
        end
        add_config(slbt_pkg::CFG_LAYER_COUNT, 1);
        add_config(slbt_pkg::CFG_MIP_COUNT, 1);
        add_request(slbt_pkg::LAYOUT_GENERAL, 4, 0, 1, 0, 1, 6, 0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (work_q.size() != 0 || have_op || start) @(posedge i_clk);
        while (barrier_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0 && barrier_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
src/slbt_pkg.sv
src/slbt_ctrl.sv
src/slbt_datapath.sv
src/subresource_layout_barrier_tracker.sv
tb/tb_subresource_layout_barrier_tracker.sv
